[rtl/core/tnl_pkg.sv]
// ----------------------------------------------------------------------------
// tnl_pkg - shared types and constants for the top-10 nearest L2 selector
// Request and response payloads, queue entry, field widths and defaults.
// ----------------------------------------------------------------------------
package tnl_pkg;

    localparam int VEC_DIM_DEF = 128;
    localparam int TOP_K_DEF   = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam int IDX_BITS  = 7;
    localparam int ELEM_BITS = 8;
    localparam int ID_BITS   = 20;
    localparam int DIST_BITS = 23;
    localparam int RANK_BITS = 4;
    localparam int SQ_BITS   = 2 * ELEM_BITS;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_CAND  = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [IDX_BITS-1:0]  elem_index;
        logic [ELEM_BITS-1:0] elem_value;
        logic [ID_BITS-1:0]   cand_id;
        logic                 last_candidate;
    } t_req;

    typedef struct packed {
        logic [RANK_BITS-1:0] out_rank;
        logic [ID_BITS-1:0]   out_id;
        logic [DIST_BITS-1:0] out_distance;
        logic                 out_valid;
        logic                 out_last;
    } t_rsp;

    typedef struct packed {
        logic [ELEM_BITS-1:0] diff;
        logic                 start;
        logic                 final_elem;
        logic [ID_BITS-1:0]   cand_id;
        logic                 last_candidate;
    } t_work;

endpackage

[rtl/core/tnl_front.sv]
// ----------------------------------------------------------------------------
// tnl_front - request intake and query store
// Accepts requests, stores query components, reads the query component
// for each candidate component and forms the absolute difference.
// ----------------------------------------------------------------------------
module tnl_front #(
    parameter int VEC_DIM = tnl_pkg::VEC_DIM_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  tnl_pkg::t_req  i_req,
    input  logic           i_q_full,
    output logic           o_push,
    output tnl_pkg::t_work o_work
);
    import tnl_pkg::*;

    localparam int AW = (VEC_DIM > 1) ? $clog2(VEC_DIM) : 1;

    logic [ELEM_BITS-1:0] r_mem [VEC_DIM];
    logic [ELEM_BITS-1:0] r_q;
    logic                 r_s1_valid;
    t_req                 r_s1;

    logic          s1_adv;
    logic          accept;
    logic          in_range;
    logic [AW-1:0] addr;

    assign s1_adv   = !r_s1_valid || !i_q_full;
    assign o_stall  = !s1_adv;
    assign accept   = i_valid && s1_adv;
    assign in_range = 32'(i_req.elem_index) < VEC_DIM;
    assign addr     = AW'(i_req.elem_index);

    always_ff @(posedge i_clk) begin
        if (accept && in_range && i_req.cmd == CMD_QUERY) begin
            r_mem[addr] <= i_req.elem_value;
        end
        if (accept && in_range && i_req.cmd == CMD_CAND) begin
            r_q <= r_mem[addr];
        end
        if (accept) begin
            r_s1 <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= accept && in_range && i_req.cmd == CMD_CAND;
        end
    end

    assign o_push = r_s1_valid && !i_q_full;

    always_comb begin
        o_work.diff           = (r_s1.elem_value > r_q) ? r_s1.elem_value - r_q
                                                        : r_q - r_s1.elem_value;
        o_work.start          = r_s1.elem_index == '0;
        o_work.final_elem     = 32'(r_s1.elem_index) == VEC_DIM - 1;
        o_work.cand_id        = r_s1.cand_id;
        o_work.last_candidate = r_s1.last_candidate;
    end

endmodule

[rtl/core/tnl_queue.sv]
// ----------------------------------------------------------------------------
// tnl_queue - short queue between intake and distance back end
// Circular buffer of work entries with full and empty flags.
// ----------------------------------------------------------------------------
module tnl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tnl_pkg::t_work i_work,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tnl_pkg::t_work o_work
);
    import tnl_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_work         r_buf [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = r_count == CW'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_work  = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

[rtl/core/tnl_back.sv]
// ----------------------------------------------------------------------------
// tnl_back - distance accumulation, ranked insert and list emission
// Squares differences, accumulates per candidate, inserts finished
// candidates into the sorted list and streams the list out on demand.
// ----------------------------------------------------------------------------
module tnl_back #(
    parameter int TOP_K = tnl_pkg::TOP_K_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  tnl_pkg::t_work i_work,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output tnl_pkg::t_rsp  o_rsp
);
    import tnl_pkg::*;

    localparam int RW       = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int SUM_BITS = ((SQ_BITS > DIST_BITS) ? SQ_BITS : DIST_BITS) + 1;

    logic                 r_m_valid;
    logic [SQ_BITS-1:0]   r_sq;
    logic                 r_m_start;
    logic                 r_m_final;
    logic [ID_BITS-1:0]   r_m_id;
    logic                 r_m_last;

    logic [DIST_BITS-1:0] r_acc;

    logic                 r_ins_valid;
    logic [DIST_BITS-1:0] r_ins_dist;
    logic [ID_BITS-1:0]   r_ins_id;
    logic                 r_ins_last;

    logic [DIST_BITS-1:0] r_dist [TOP_K];
    logic [ID_BITS-1:0]   r_id [TOP_K];
    logic [TOP_K-1:0]     r_slot_valid;

    logic [DIST_BITS-1:0] r_e_dist [TOP_K];
    logic [ID_BITS-1:0]   r_e_id [TOP_K];
    logic [TOP_K-1:0]     r_e_valid;
    logic                 r_emit_busy;
    logic [RW-1:0]        r_rank;

    logic                 emit_free;
    logic                 adv;
    logic [SUM_BITS-1:0]  sum;
    logic [DIST_BITS-1:0] acc_next;
    logic [TOP_K-1:0]     near;
    logic [DIST_BITS-1:0] n_dist [TOP_K];
    logic [ID_BITS-1:0]   n_id [TOP_K];
    logic [TOP_K-1:0]     n_slot_valid;

    assign emit_free = !r_emit_busy || (!i_stall && r_rank == RW'(TOP_K - 1));
    assign adv       = !(r_ins_valid && r_ins_last && !emit_free);
    assign o_pop     = adv && !i_empty;

    assign sum      = (r_m_start ? '0 : SUM_BITS'(r_acc)) + SUM_BITS'(r_sq);
    assign acc_next = (sum > SUM_BITS'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(sum);

    always_comb begin
        for (int p = 0; p < TOP_K; p++) begin
            near[p] = !r_slot_valid[p] || r_ins_dist < r_dist[p];
        end
        for (int p = 0; p < TOP_K; p++) begin
            n_dist[p]       = r_dist[p];
            n_id[p]         = r_id[p];
            n_slot_valid[p] = r_slot_valid[p];
            if (p == 0) begin
                if (near[p]) begin
                    n_dist[p]       = r_ins_dist;
                    n_id[p]         = r_ins_id;
                    n_slot_valid[p] = 1'b1;
                end
            end else if (near[p] && near[p-1]) begin
                n_dist[p]       = r_dist[p-1];
                n_id[p]         = r_id[p-1];
                n_slot_valid[p] = r_slot_valid[p-1];
            end else if (near[p]) begin
                n_dist[p]       = r_ins_dist;
                n_id[p]         = r_ins_id;
                n_slot_valid[p] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq      <= SQ_BITS'(i_work.diff) * SQ_BITS'(i_work.diff);
            r_m_start <= i_work.start;
            r_m_final <= i_work.final_elem;
            r_m_id    <= i_work.cand_id;
            r_m_last  <= i_work.last_candidate;
            if (r_m_valid && r_m_final) begin
                r_ins_dist <= acc_next;
                r_ins_id   <= r_m_id;
                r_ins_last <= r_m_last;
            end
            if (r_ins_valid) begin
                r_dist <= n_dist;
                r_id   <= n_id;
                if (r_ins_last) begin
                    r_e_dist <= n_dist;
                    r_e_id   <= n_id;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid    <= 1'b0;
            r_acc        <= '0;
            r_ins_valid  <= 1'b0;
            r_slot_valid <= '0;
            r_e_valid    <= '0;
            r_emit_busy  <= 1'b0;
            r_rank       <= '0;
        end else begin
            if (adv && r_ins_valid && r_ins_last) begin
                r_emit_busy <= 1'b1;
                r_rank      <= '0;
            end else if (r_emit_busy && !i_stall) begin
                if (r_rank == RW'(TOP_K - 1)) begin
                    r_emit_busy <= 1'b0;
                end else begin
                    r_rank <= r_rank + 1'b1;
                end
            end
            if (adv) begin
                r_m_valid   <= !i_empty;
                r_ins_valid <= r_m_valid && r_m_final;
                if (r_m_valid) begin
                    r_acc <= r_m_final ? '0 : acc_next;
                end
                if (r_ins_valid) begin
                    if (r_ins_last) begin
                        r_slot_valid <= '0;
                        r_e_valid    <= n_slot_valid;
                    end else begin
                        r_slot_valid <= n_slot_valid;
                    end
                end
            end
        end
    end

    assign o_valid = r_emit_busy;

    always_comb begin
        o_rsp.out_rank     = RANK_BITS'(r_rank);
        o_rsp.out_valid    = r_e_valid[r_rank];
        o_rsp.out_id       = r_e_valid[r_rank] ? r_e_id[r_rank] : '0;
        o_rsp.out_distance = r_e_valid[r_rank] ? r_e_dist[r_rank] : '0;
        o_rsp.out_last     = r_rank == RW'(TOP_K - 1);
    end

endmodule

[rtl/core/top10_nearest_l2_select.sv]
// ----------------------------------------------------------------------------
// top10_nearest_l2_select - brute-force nearest neighbor selector, squared L2
//
// Input channel (i_valid / o_stall / i_req): one vector component per
// request. cmd query writes the query store; cmd candidate adds the squared
// difference to the running distance of candidate cand_id. Components whose
// index is not below VEC_DIM are dropped. On a candidate's final component
// the candidate joins the sorted list of the TOP_K nearest; ties keep the
// earlier candidate.
// Output channel (o_valid / i_stall / o_rsp): after the candidate flagged
// last, the TOP_K ranked slots leave one per cycle, rank 0 first, out_last
// on the final slot, then the list is empty again.
// Throughput: one request per cycle while o_stall is low. The first slot
// is presented once the final component of the last candidate has passed
// the intake register, the queue, the square stage and the insert stage.
// A second list finished during emission waits in the back end, and the
// four-entry queue then fills and raises o_stall. A stalled receiver holds
// the current slot. Reset clears the list, the accumulator and the queue;
// query store contents are unknown until written.
// ----------------------------------------------------------------------------
module top10_nearest_l2_select #(
    parameter int VEC_DIM = tnl_pkg::VEC_DIM_DEF,
    parameter int TOP_K   = tnl_pkg::TOP_K_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  tnl_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output tnl_pkg::t_rsp o_rsp
);
    import tnl_pkg::*;

    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    t_work work_in;
    t_work work_out;

    tnl_front #(
        .VEC_DIM (VEC_DIM)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_work   (work_in)
    );

    tnl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (work_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_work  (work_out)
    );

    tnl_back #(
        .TOP_K (TOP_K)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_work  (work_out),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

endmodule

[bench/tb_top10_nearest_l2_select.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top10_nearest_l2_select - testbench for the top-10 nearest L2 selector
// Streams sparse query and candidate vectors through the request channel
// with bursty sending and a patterned receiver stall. A local ranking model
// predicts every emitted slot, and the monitor compares each slot field by
// field. The directed part covers an all-opposite candidate, a zero
// distance, a tie and empty slots. It also covers ignored last flags, a
// candidate that restarts and single-candidate lists back to back.
// Randomized sets follow, with an overflowing list, query patches and
// interrupted candidates.
// ----------------------------------------------------------------------------
module tb_top10_nearest_l2_select;
    import tnl_pkg::*;

    localparam int VEC_DIM     = VEC_DIM_DEF;
    localparam int TOP_K       = TOP_K_DEF;
    localparam int STALL_LIMIT = 3000;

    typedef enum int {QRY_BASE, QRY_PATCH} qry_kind_e;
    typedef enum int {CAND_RANDOM, CAND_EQUAL, CAND_FAR, CAND_NEAR, CAND_TWIN} cand_kind_e;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_req i_req = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_rsp o_rsp;

    top10_nearest_l2_select uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    // ranking model state
    logic [ELEM_BITS-1:0] qref [VEC_DIM];
    logic [DIST_BITS-1:0] run_dist = '0;
    logic [DIST_BITS-1:0] rank_dist [TOP_K] = '{default: '0};
    logic [ID_BITS-1:0]   rank_id [TOP_K] = '{default: '0};
    logic                 rank_full [TOP_K] = '{default: 1'b0};

    t_req req_q[$];
    t_rsp slot_expect_q[$];

    int qshadow [VEC_DIM];
    bit qwritten [VEC_DIM] = '{default: 1'b0};
    int twin_vec [VEC_DIM];

    int  n_pushed = 0;
    int  n_accepted = 0;
    int  n_cands = 0;
    int  n_lists = 0;
    int  n_slots = 0;
    int  err_cnt = 0;
    int  idle_cycles = 0;
    int  burst_left = 50;
    int  gap_left = 0;
    int  rx_mode = 0;
    int  rx_left = 0;
    int  rx_tick = 0;
    bit  req_taken = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic beats(input logic [DIST_BITS-1:0] d, input int s);
        return !rank_full[s] || d < rank_dist[s];
    endfunction

    task automatic predict_request(input t_req r);
        logic [ELEM_BITS-1:0] diff;
        logic [DIST_BITS-1:0] d;
        longint unsigned      sum;
        int                   p;
        t_rsp                 slot;
        if (r.elem_index >= VEC_DIM) return;
        if (r.cmd == CMD_QUERY) begin
            qref[r.elem_index] = r.elem_value;
            return;
        end
        diff = (r.elem_value > qref[r.elem_index]) ? r.elem_value - qref[r.elem_index]
                                                   : qref[r.elem_index] - r.elem_value;
        sum = longint'(diff) * longint'(diff);
        if (r.elem_index != 0) sum = sum + run_dist;
        run_dist = (sum > DIST_MAX) ? DIST_MAX : sum[DIST_BITS-1:0];
        if (r.elem_index != VEC_DIM - 1) return;
        d = run_dist;
        run_dist = '0;
        n_cands++;
        p = TOP_K - 1;
        if (beats(d, p)) begin
            while (p > 0 && beats(d, p - 1)) begin
                rank_dist[p] = rank_dist[p-1];
                rank_id[p]   = rank_id[p-1];
                rank_full[p] = rank_full[p-1];
                p--;
            end
            rank_dist[p] = d;
            rank_id[p]   = r.cand_id;
            rank_full[p] = 1'b1;
        end
        if (!r.last_candidate) return;
        for (int k = 0; k < TOP_K; k++) begin
            slot.out_rank     = RANK_BITS'(k);
            slot.out_id       = rank_full[k] ? rank_id[k] : '0;
            slot.out_distance = rank_full[k] ? rank_dist[k] : '0;
            slot.out_valid    = rank_full[k];
            slot.out_last     = (k == TOP_K - 1);
            slot_expect_q.push_back(slot);
            rank_full[k] = 1'b0;
            rank_dist[k] = '0;
            rank_id[k]   = '0;
        end
        n_lists++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // request side: record acceptance, run the model
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_stall == 1'b0) begin
            predict_request(i_req);
            n_accepted++;
            req_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        t_req nxt_req;
        logic nxt_valid;
        nxt_req = i_req;
        nxt_valid = i_valid;
        if (i_rst_n && (!i_valid || req_taken)) begin
            req_taken = 1'b0;
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (req_q.size() > 0) begin
                nxt_req = req_q.pop_front();
                nxt_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    gap_left = $urandom_range(1, 12);
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                             : $urandom_range(1, 30);
                end
            end
        end
        i_valid <= nxt_valid;
        i_req <= nxt_req;
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        logic nxt_stall;
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0: nxt_stall = 1'b0;
            1: nxt_stall = 1'($urandom_range(0, 1));
            2: nxt_stall = (rx_tick % 7) < 3;
            default: nxt_stall = (rx_tick % 25) < 18;
        endcase
        i_stall <= nxt_stall;
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (slot_expect_q.size() == 0) begin
                $error("Unexpected slot: rank %0d id %0d distance %0d",
                       o_rsp.out_rank, o_rsp.out_id, o_rsp.out_distance);
                err_cnt++;
            end else begin
                want = slot_expect_q.pop_front();
                check_field("out_rank", 32'(want.out_rank), 32'(o_rsp.out_rank));
                check_field("out_id", 32'(want.out_id), 32'(o_rsp.out_id));
                check_field("out_distance", 32'(want.out_distance),
                            32'(o_rsp.out_distance));
                check_field("out_valid", 32'(want.out_valid), 32'(o_rsp.out_valid));
                check_field("out_last", 32'(want.out_last), 32'(o_rsp.out_last));
                n_slots++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_stall == 1'b0) || (o_valid === 1'b1 && i_stall == 1'b0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int rand_component();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 255 : 0;
        return $urandom_range(0, 255);
    endfunction

    task automatic push_req(input logic cmd, input int idx, input int val,
                            input logic [ID_BITS-1:0] id, input logic last);
        t_req r;
        r.cmd            = cmd;
        r.elem_index     = IDX_BITS'(idx);
        r.elem_value     = ELEM_BITS'(val);
        r.cand_id        = id;
        r.last_candidate = last;
        req_q.push_back(r);
        n_pushed++;
        if (cmd == CMD_QUERY) begin
            qshadow[idx]  = val;
            qwritten[idx] = 1'b1;
        end
    endtask

    task automatic push_query(input qry_kind_e kind);
        int n;
        int idx;
        if (kind == QRY_BASE) begin
            push_req(CMD_QUERY, VEC_DIM - 1, 255, ID_BITS'($urandom),
                     1'($urandom_range(0, 1)));
            for (int i = 0; i < 5; i++)
                push_req(CMD_QUERY, i * 25, 255, ID_BITS'($urandom),
                         1'($urandom_range(0, 1)));
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                idx = $urandom_range(0, VEC_DIM - 1);
                push_req(CMD_QUERY, idx, rand_component(), ID_BITS'($urandom),
                         1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic push_candidate(input logic [ID_BITS-1:0] id, input logic last,
                                  input cand_kind_e kind, input int stop_at);
        int v;
        bit poke;
        poke = kind == CAND_RANDOM && stop_at == VEC_DIM && $urandom_range(0, 3) == 0;
        for (int i = 0; i < stop_at; i++) begin
            if (qwritten[i] && (kind != CAND_RANDOM || i == 0 || i == VEC_DIM - 1
                                || $urandom_range(0, 2) != 0)) begin
                if (poke && i != 0) begin
                    push_req(CMD_QUERY, $urandom_range(0, VEC_DIM - 1), rand_component(),
                             ID_BITS'($urandom), 1'b0);
                    poke = 1'b0;
                end
                case (kind)
                    CAND_RANDOM: v = rand_component();
                    CAND_EQUAL:  v = qshadow[i];
                    CAND_FAR:    v = (qshadow[i] < 128) ? 255 : 0;
                    CAND_NEAR: begin
                        v = qshadow[i] + int'($urandom_range(0, 6)) - 3;
                        if (v < 0) v = 0;
                        if (v > 255) v = 255;
                    end
                    default:     v = twin_vec[i];
                endcase
                twin_vec[i] = v;
                push_req(CMD_CAND, i, v, id,
                         (i == VEC_DIM - 1) ? last : 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic wait_drained();
        while (!(n_accepted == n_pushed && slot_expect_q.size() == 0))
            @(negedge i_clk);
    endtask

    initial begin
        int                 ncand;
        cand_kind_e         kind;
        logic [ID_BITS-1:0] id;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // farthest, exact match and a tie; seven slots stay empty
        push_query(QRY_BASE);
        push_candidate(20'h00000, 1'b0, CAND_FAR, VEC_DIM);
        push_candidate(20'hFFFFF, 1'b0, CAND_EQUAL, VEC_DIM);
        push_candidate(20'h00005, 1'b1, CAND_TWIN, VEC_DIM);
        wait_drained();

        // abandon a candidate halfway and restart at index zero
        push_candidate(20'h12345, 1'b0, CAND_RANDOM, VEC_DIM / 2);
        push_candidate(20'h54321, 1'b1, CAND_NEAR, VEC_DIM);

        // single-candidate lists back to back
        for (int j = 0; j < 4; j++)
            push_req(CMD_CAND, VEC_DIM - 1, rand_component(), ID_BITS'(j + 1), 1'b1);
        wait_drained();

        for (int s = 0; s < 3; s++) begin
            if (s > 0 || $urandom_range(0, 1) == 0)
                push_query(QRY_PATCH);
            ncand = (s == 0) ? 11 : $urandom_range(1, 2);
            for (int c = 0; c < ncand; c++) begin
                case ($urandom_range(0, 7))
                    0: id = '0;
                    1: id = '1;
                    default: id = ID_BITS'($urandom);
                endcase
                if ($urandom_range(0, 5) == 0)
                    push_candidate(ID_BITS'($urandom), 1'b0, CAND_RANDOM,
                                   $urandom_range(1, VEC_DIM - 1));
                kind = cand_kind_e'($urandom_range(0, 4));
                push_candidate(id, c == ncand - 1, kind, VEC_DIM);
            end
            if (s == 1) wait_drained();
        end

        wait_drained();
        repeat (40) @(negedge i_clk);
        $display("Run covered %0d requests: %0d candidates ranked into %0d lists,",
                 n_accepted, n_cands, n_lists);
        $display("%0d ranked slots compared under bursty sending and receiver stalls.",
                 n_slots);
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/tnl_pkg.sv
rtl/core/tnl_front.sv
rtl/core/tnl_queue.sv
rtl/core/tnl_back.sv
rtl/core/top10_nearest_l2_select.sv
bench/tb_top10_nearest_l2_select.sv
